### design/ffa_pkg.sv
package ffa_pkg;

    localparam int ADDR_W      = 14;
    localparam int ARENA_UNITS = 1 << ADDR_W;
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int BYTES_W     = 18;
    localparam int UNIT_BYTES  = 16;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
    localparam int WALK_LIMIT  = 4 * ARENA_UNITS + 8;
    localparam int STEP_W      = $clog2(WALK_LIMIT + 2);
    localparam int CFG_IDX_W   = 1;

    localparam logic [BYTES_W-1:0] RESET_MAX_REQUEST = BYTES_W'(10240);
    localparam logic [SIZE_W-1:0]  RESET_MIN_GROW    = SIZE_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GROW    = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_DONATE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_NO_MEM    = 3'd2,
        ST_REFUSED   = 3'd3,
        ST_TOO_SMALL = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_TAKE,
        CMD_DISP,
        CMD_AREST,
        CMD_ALINK,
        CMD_AEVAL,
        CMD_ASPLIT,
        CMD_GROW,
        CMD_RHEAD,
        CMD_RSIZE,
        CMD_RWALK,
        CMD_MNEXT,
        CMD_MPREV,
        CMD_FIN
    } t_cmd;

    typedef struct packed {
        t_cmd    cmd;
        t_status st;
    } t_ctl;

    typedef struct packed {
        t_op  op;
        logic too_big;
        logic free_bad;
        logic donate_small;
        logic donate_bad;
        logic a_over;
        logic fit;
        logic exact;
        logic p_is_rover;
        logic grow_fail;
        logic big;
        logic found;
        logic walk_limit;
        logic out_full;
    } t_flags;

endpackage

### design/ffa_req_if.sv
interface ffa_req_if;
    import ffa_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [BYTES_W-1:0]  byte_count;
    logic [ADDR_W-1:0]   address;

    modport source (output valid, output op, output byte_count, output address, input ready);
    modport sink   (input valid, input op, input byte_count, input address, output ready);
endinterface

### design/ffa_rsp_if.sv
interface ffa_rsp_if;
    import ffa_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  block_address;
    logic [SIZE_W-1:0]  units;
    logic [2:0]         status;

    modport source (output valid, output block_address, output units, output status,
                    input ready);
    modport sink   (input valid, input block_address, input units, input status,
                    output ready);
endinterface

### design/ffa_ram.sv
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/ffa_dp.sv
module ffa_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffa_pkg::BYTES_W-1:0]    i_cfg_data,
    input  logic [1:0]                     i_op,
    input  logic [ffa_pkg::BYTES_W-1:0]    i_byte_count,
    input  logic [ffa_pkg::ADDR_W-1:0]     i_address,
    input  ffa_pkg::t_ctl                  i_ctl,
    output ffa_pkg::t_flags                o_flags,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ffa_pkg::ADDR_W-1:0]     o_block_address,
    output logic [ffa_pkg::SIZE_W-1:0]     o_units,
    output logic [2:0]                     o_status
);
    import ffa_pkg::*;

    localparam int SUM_W = SIZE_W + 1;

    t_op                r_op;
    logic [BYTES_W-1:0] r_bytes;
    logic [ADDR_W-1:0]  r_addr;
    logic [SIZE_W-1:0]  r_need;
    logic [BYTES_W-1:0] r_max;
    logic [SIZE_W-1:0]  r_grow;
    logic [ADDR_W-1:0]  r_rover;
    logic [SIZE_W-1:0]  r_brk;
    logic [SIZE_W-1:0]  r_large;
    logic [ADDR_W-1:0]  r_p;
    logic [ADDR_W-1:0]  r_prev;
    logic [ADDR_W-1:0]  r_bp;
    logic [ADDR_W-1:0]  r_nx;
    logic [ADDR_W-1:0]  r_lbp;
    logic [SIZE_W-1:0]  r_szbp;
    logic [SIZE_W-1:0]  r_szp;
    logic [STEP_W-1:0]  r_asteps;
    logic [STEP_W-1:0]  r_rsteps;
    logic [ADDR_W-1:0]  r_blk;
    logic [SIZE_W-1:0]  r_units;
    logic               r_ov;
    logic [ADDR_W-1:0]  r_ob;
    logic [SIZE_W-1:0]  r_ou;
    logic [2:0]         r_os;
    logic               r_rd0;
    logic               r_l0v;
    logic               r_s0v;
    logic               r_split_oor;

    logic [ADDR_W-1:0]  lk_q;
    logic [SIZE_W-1:0]  sz_q;
    logic [ADDR_W-1:0]  rd_link;
    logic [SIZE_W-1:0]  rd_size;
    logic [ADDR_W-1:0]  raddr;
    logic               lwe;
    logic [ADDR_W-1:0]  lwa;
    logic [ADDR_W-1:0]  lwd;
    logic               swe;
    logic [ADDR_W-1:0]  swa;
    logic [SIZE_W-1:0]  swd;
    logic [SIZE_W-1:0]  nu;
    logic [SUM_W-1:0]   grow_sum;
    logic [SUM_W-1:0]   split_sum;
    logic [SIZE_W-1:0]  donate_units;
    logic [SIZE_W-1:0]  need_in;
    logic               merge_hi;
    logic               merge_lo;
    logic               c_in;
    logic               c_wrap;
    logic               dn_ok;

    ffa_ram #(.WIDTH(ADDR_W), .DEPTH(ARENA_UNITS)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (lwe),
        .i_waddr(lwa),
        .i_wdata(lwd),
        .i_raddr(raddr),
        .o_rdata(lk_q)
    );

    ffa_ram #(.WIDTH(SIZE_W), .DEPTH(ARENA_UNITS)) u_size_ram (
        .i_clk  (i_clk),
        .i_we   (swe),
        .i_waddr(swa),
        .i_wdata(swd),
        .i_raddr(raddr),
        .o_rdata(sz_q)
    );

    // sentinel reads as self-linked, size zero until written
    assign rd_link = (r_rd0 && !r_l0v) ? '0 : lk_q;
    assign rd_size = (r_rd0 && !r_s0v) ? '0 : sz_q;

    assign need_in      = SIZE_W'((({1'b0, i_byte_count} + (BYTES_W+1)'(UNIT_BYTES - 1))
                                   >> UNIT_SHIFT) + 1);
    assign donate_units = SIZE_W'(r_bytes >> UNIT_SHIFT);
    assign nu           = (r_need < r_grow) ? r_grow : r_need;
    assign grow_sum     = SUM_W'(r_brk) + SUM_W'(nu);
    assign split_sum    = SUM_W'(r_p) + SUM_W'(rd_size - r_need);
    assign merge_hi     = (SUM_W'(r_bp) + SUM_W'(r_szbp)) == SUM_W'(r_nx);
    assign merge_lo     = (SUM_W'(r_p) + SUM_W'(r_szp)) == SUM_W'(r_bp);
    assign c_in         = (r_bp > r_p) && (r_bp < rd_link);
    assign c_wrap       = (r_p >= rd_link) && ((r_bp > r_p) || (r_bp < rd_link));
    assign dn_ok        = (r_bytes >= BYTES_W'(UNIT_BYTES)) && (r_addr != '0);

    always_comb begin
        o_flags.op           = r_op;
        o_flags.too_big      = r_bytes > r_max;
        o_flags.free_bad     = r_addr < ADDR_W'(2);
        o_flags.donate_small = r_bytes < BYTES_W'(UNIT_BYTES);
        o_flags.donate_bad   = r_addr == '0;
        o_flags.a_over       = r_asteps > STEP_W'(WALK_LIMIT);
        o_flags.fit          = rd_size >= r_need;
        o_flags.exact        = rd_size == r_need;
        o_flags.p_is_rover   = r_p == r_rover;
        o_flags.grow_fail    = grow_sum > SUM_W'(ARENA_UNITS);
        o_flags.big          = rd_size > r_large;
        o_flags.found        = c_in || c_wrap;
        o_flags.walk_limit   = r_rsteps >= STEP_W'(WALK_LIMIT);
        o_flags.out_full     = r_ov;
    end

    always_comb begin
        raddr = r_rover;
        lwe   = 1'b0;
        lwa   = r_p;
        lwd   = rd_link;
        swe   = 1'b0;
        swa   = r_p;
        swd   = r_need;
        unique case (i_ctl.cmd)
            CMD_ALINK, CMD_AEVAL, CMD_RWALK: begin
                raddr = rd_link;
            end
            CMD_RHEAD: begin
                raddr = r_bp;
            end
            default: begin
                raddr = r_rover;
            end
        endcase
        unique case (i_ctl.cmd)
            CMD_DISP: begin
                if (r_op == OP_DONATE && dn_ok) begin
                    swe = 1'b1;
                    swa = r_addr;
                    swd = donate_units;
                end
            end
            CMD_AEVAL: begin
                if (!o_flags.a_over && o_flags.fit) begin
                    if (o_flags.exact) begin
                        lwe = 1'b1;
                        lwa = r_prev;
                        lwd = rd_link;
                    end else begin
                        swe = 1'b1;
                        swa = r_p;
                        swd = rd_size - r_need;
                    end
                end
            end
            CMD_ASPLIT: begin
                // tail header beyond the arena end is not stored
                swe = !r_split_oor;
                swa = r_p;
                swd = r_need;
            end
            CMD_GROW: begin
                if (!o_flags.grow_fail) begin
                    swe = 1'b1;
                    swa = r_brk[ADDR_W-1:0];
                    swd = nu;
                end
            end
            CMD_MNEXT: begin
                lwe = 1'b1;
                lwa = r_bp;
                swa = r_bp;
                if (merge_hi) begin
                    swe = 1'b1;
                    swd = r_szbp + rd_size;
                    lwd = rd_link;
                end else begin
                    lwd = r_nx;
                end
            end
            CMD_MPREV: begin
                lwe = 1'b1;
                lwa = r_p;
                swa = r_p;
                if (merge_lo) begin
                    swe = 1'b1;
                    swd = r_szp + r_szbp;
                    lwd = r_lbp;
                end else begin
                    lwd = r_bp;
                end
            end
            default: begin
                lwe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover <= '0;
            r_brk   <= SIZE_W'(1);
            r_large <= '0;
            r_max   <= RESET_MAX_REQUEST;
            r_grow  <= RESET_MIN_GROW;
            r_ov    <= 1'b0;
            r_l0v   <= 1'b0;
            r_s0v   <= 1'b0;
            r_rd0   <= 1'b0;
            r_op    <= OP_NONE;
        end else begin
            r_rd0 <= raddr == '0;
            if (lwe && lwa == '0) begin
                r_l0v <= 1'b1;
            end
            if (swe && swa == '0) begin
                r_s0v <= 1'b1;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_REQUEST) begin
                    r_max <= i_cfg_data;
                end else begin
                    r_grow <= i_cfg_data[SIZE_W-1:0];
                end
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (i_ctl.cmd)
                CMD_TAKE: begin
                    r_op    <= t_op'(i_op);
                    r_bytes <= i_byte_count;
                    r_addr  <= i_address;
                    r_need  <= need_in;
                    r_blk   <= '0;
                    r_units <= '0;
                end
                CMD_DISP: begin
                    r_prev   <= r_rover;
                    r_asteps <= '0;
                    if (r_op == OP_FREE) begin
                        r_bp <= r_addr - ADDR_W'(1);
                    end else begin
                        r_bp <= r_addr;
                    end
                    if (r_op == OP_DONATE && dn_ok) begin
                        r_units <= donate_units;
                    end
                end
                CMD_AREST: begin
                    r_prev <= r_rover;
                end
                CMD_ALINK: begin
                    r_p <= rd_link;
                end
                CMD_AEVAL: begin
                    r_asteps <= r_asteps + STEP_W'(1);
                    if (!o_flags.a_over) begin
                        if (o_flags.fit) begin
                            if (o_flags.exact) begin
                                r_rover <= r_prev;
                                r_blk   <= r_p + ADDR_W'(1);
                                r_units <= r_need;
                            end else begin
                                r_p         <= split_sum[ADDR_W-1:0];
                                r_split_oor <= split_sum >= SUM_W'(ARENA_UNITS);
                            end
                        end else if (!o_flags.p_is_rover) begin
                            r_prev <= r_p;
                            r_p    <= rd_link;
                        end
                    end
                end
                CMD_ASPLIT: begin
                    r_rover <= r_prev;
                    r_blk   <= r_p + ADDR_W'(1);
                    r_units <= r_need;
                end
                CMD_GROW: begin
                    if (!o_flags.grow_fail) begin
                        r_bp  <= r_brk[ADDR_W-1:0];
                        r_brk <= grow_sum[SIZE_W-1:0];
                        if (nu > r_large) begin
                            r_large <= nu;
                        end
                    end
                end
                CMD_RSIZE: begin
                    r_szbp   <= rd_size;
                    r_p      <= r_rover;
                    r_rsteps <= '0;
                end
                CMD_RWALK: begin
                    if (o_flags.found) begin
                        r_nx  <= rd_link;
                        r_szp <= rd_size;
                    end else begin
                        r_rsteps <= r_rsteps + STEP_W'(1);
                        r_p      <= rd_link;
                    end
                end
                CMD_MNEXT: begin
                    if (merge_hi) begin
                        r_szbp <= r_szbp + rd_size;
                        r_lbp  <= rd_link;
                    end else begin
                        r_lbp <= r_nx;
                    end
                end
                CMD_MPREV: begin
                    r_rover <= r_p;
                end
                CMD_FIN: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_ob <= r_blk;
                        r_ou <= r_units;
                        r_os <= i_ctl.st;
                    end
                end
                default: begin
                    r_op <= r_op;
                end
            endcase
        end
    end

    assign o_out_valid     = r_ov;
    assign o_block_address = r_ob;
    assign o_units         = r_ou;
    assign o_status        = r_os;

    a_brk_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_brk >= $past(r_brk))
        else $error("break pointer moved back");

    a_brk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> SUM_W'(r_brk) <= SUM_W'(ARENA_UNITS))
        else $error("break pointer beyond arena");

    a_large_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_large >= $past(r_large))
        else $error("largest chunk shrank");
endmodule

### design/ffa_ctrl.sv
module ffa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffa_pkg::t_flags i_flags,
    output ffa_pkg::t_ctl   o_ctl
);
    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_AREST,
        S_ALINK,
        S_AEVAL,
        S_ASPLIT,
        S_GROW,
        S_RHEAD,
        S_RSIZE,
        S_RWALK,
        S_MNEXT,
        S_MPREV,
        S_FIN
    } t_state;

    t_state  r_state, n_state;
    t_status r_st, n_st;
    t_state  rel_ok_state;
    t_state  rel_bad_state;
    t_status rel_bad_st;

    assign rel_ok_state  = (i_flags.op == OP_ALLOC) ? S_AREST : S_FIN;
    assign rel_bad_state = (i_flags.op == OP_ALLOC) ? S_AREST : S_FIN;
    assign rel_bad_st    = (i_flags.op == OP_ALLOC) ? r_st : ST_REFUSED;

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        unique case (r_state)
            S_IDLE: begin
                n_st = ST_OK;
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_flags.op)
                    OP_ALLOC: begin
                        if (i_flags.too_big) begin
                            n_state = S_FIN;
                            n_st    = ST_TOO_LARGE;
                        end else begin
                            n_state = S_ALINK;
                        end
                    end
                    OP_FREE: begin
                        if (i_flags.free_bad) begin
                            n_state = S_FIN;
                            n_st    = ST_REFUSED;
                        end else begin
                            n_state = S_RHEAD;
                        end
                    end
                    OP_DONATE: begin
                        if (i_flags.donate_small) begin
                            n_state = S_FIN;
                            n_st    = ST_TOO_SMALL;
                        end else if (i_flags.donate_bad) begin
                            n_state = S_FIN;
                            n_st    = ST_REFUSED;
                        end else begin
                            n_state = S_RHEAD;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_AREST: n_state = S_ALINK;
            S_ALINK: n_state = S_AEVAL;
            S_AEVAL: begin
                if (i_flags.a_over) begin
                    n_state = S_FIN;
                    n_st    = ST_NO_MEM;
                end else if (i_flags.fit && i_flags.exact) begin
                    n_state = S_FIN;
                end else if (i_flags.fit) begin
                    n_state = S_ASPLIT;
                end else if (i_flags.p_is_rover) begin
                    n_state = S_GROW;
                end
            end
            S_ASPLIT: n_state = S_FIN;
            S_GROW: begin
                if (i_flags.grow_fail) begin
                    n_state = S_FIN;
                    n_st    = ST_NO_MEM;
                end else begin
                    n_state = S_RHEAD;
                end
            end
            S_RHEAD: n_state = S_RSIZE;
            S_RSIZE: begin
                if (i_flags.big) begin
                    n_state = rel_bad_state;
                    n_st    = rel_bad_st;
                end else begin
                    n_state = S_RWALK;
                end
            end
            S_RWALK: begin
                if (i_flags.found) begin
                    n_state = S_MNEXT;
                end else if (i_flags.walk_limit) begin
                    n_state = rel_bad_state;
                    n_st    = rel_bad_st;
                end
            end
            S_MNEXT: n_state = S_MPREV;
            S_MPREV: n_state = rel_ok_state;
            S_FIN: begin
                if (!i_flags.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    always_comb begin
        o_ctl.st = r_st;
        unique case (r_state)
            S_IDLE:   o_ctl.cmd = i_in_valid ? CMD_TAKE : CMD_IDLE;
            S_DISP:   o_ctl.cmd = CMD_DISP;
            S_AREST:  o_ctl.cmd = CMD_AREST;
            S_ALINK:  o_ctl.cmd = CMD_ALINK;
            S_AEVAL:  o_ctl.cmd = CMD_AEVAL;
            S_ASPLIT: o_ctl.cmd = CMD_ASPLIT;
            S_GROW:   o_ctl.cmd = CMD_GROW;
            S_RHEAD:  o_ctl.cmd = CMD_RHEAD;
            S_RSIZE:  o_ctl.cmd = CMD_RSIZE;
            S_RWALK:  o_ctl.cmd = CMD_RWALK;
            S_MNEXT:  o_ctl.cmd = CMD_MNEXT;
            S_MPREV:  o_ctl.cmd = CMD_MPREV;
            S_FIN:    o_ctl.cmd = CMD_FIN;
            default:  o_ctl.cmd = CMD_IDLE;
        endcase
    end

    assign o_in_ready = r_state == S_IDLE;

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_DISP)
        else $error("accepted item not dispatched");

    a_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MNEXT |=> r_state == S_MPREV && $past(i_flags.op) == i_flags.op)
        else $error("merge sequence broken");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && i_flags.out_full) |=> r_state == S_FIN && $stable(r_st))
        else $error("result lost while output busy");
endmodule

### design/first_fit_free_list_allocator.sv
// First-fit allocator over a 16384-unit arena (16 bytes a unit), with an
// address-ordered circular free list and a roving start pointer. One item
// is worked on at a time: allocate visits the free-list nodes in turn and
// splits the chosen block unless it fits exactly, with a free-list insert
// each time the break is grown; free and donate do a free-list insert that
// walks the list to the block's place. The walk is bound by one header read
// per cycle from the header memories. A finished result waits in an output
// register while the next item is taken.
module first_fit_free_list_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffa_pkg::BYTES_W-1:0]   i_cfg_data,
    ffa_req_if.sink                       i_req,
    ffa_rsp_if.source                     o_rsp
);
    import ffa_pkg::*;

    t_ctl   ctl;
    t_flags flags;

    ffa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready),
        .i_flags   (flags),
        .o_ctl     (ctl)
    );

    ffa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_req.op),
        .i_byte_count   (i_req.byte_count),
        .i_address      (i_req.address),
        .i_ctl          (ctl),
        .o_flags        (flags),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_block_address(o_rsp.block_address),
        .o_units        (o_rsp.units),
        .o_status       (o_rsp.status)
    );
endmodule
